FILE: hw/rtl/bss_pkg.sv
// Shared types, codes and constants of the backend server selector.
package bss_pkg;

	localparam int MAX_SERVERS_DEF = 16;
	localparam int TIME_BITS_DEF   = 32;

	localparam int CW_MAX = 8191;
	localparam int CW_MIN = -8192;

	localparam logic [7:0]  FAIL_LIMIT_RST  = 8'd3;
	localparam logic [15:0] FAIL_WINDOW_RST = 16'd30;
	localparam logic [15:0] CONN_LIMIT_RST  = 16'd1000;

	localparam logic [2:0] CMD_SELECT  = 3'd0;
	localparam logic [2:0] CMD_LOAD    = 3'd1;
	localparam logic [2:0] CMD_CONN    = 3'd2;
	localparam logic [2:0] CMD_OUTCOME = 3'd3;
	localparam logic [2:0] CMD_HEALTH  = 3'd4;
	localparam logic [2:0] CMD_TICK    = 3'd5;

	localparam logic [1:0] MODE_RR   = 2'd0;
	localparam logic [1:0] MODE_SWRR = 2'd1;
	localparam logic [1:0] MODE_LC   = 2'd2;
	localparam logic [1:0] MODE_HASH = 2'd3;

	localparam logic [1:0] SLOT_UNKNOWN = 2'd0;
	localparam logic [1:0] SLOT_UP      = 2'd1;
	localparam logic [1:0] SLOT_DOWN    = 2'd2;

	localparam logic [1:0] REG_LB_MODE     = 2'd0;
	localparam logic [1:0] REG_FAIL_LIMIT  = 2'd1;
	localparam logic [1:0] REG_FAIL_WINDOW = 2'd2;
	localparam logic [1:0] REG_CONN_LIMIT  = 2'd3;

	typedef struct packed {
		logic [2:0]  cmd;
		logic [3:0]  slot;
		logic [7:0]  weight_in;
		logic        open_flag;
		logic        pass_flag;
		logic [31:0] client_hash;
	} bss_in_t;

	typedef struct packed {
		logic [3:0] chosen_slot;
		logic       chosen_valid;
	} bss_out_t;

	typedef struct packed {
		logic [7:0]         weight;
		logic signed [13:0] cur_weight;
		logic [1:0]         status;
		logic [15:0]        conns;
		logic [7:0]         fails;
	} slot_entry_t;

endpackage

FILE: hw/rtl/bss_table.sv
// Slot table memories with registered read and per-entry valid bits.
module bss_table #(
	parameter int DEPTH = 16,
	parameter int AW    = 4,
	parameter int TW    = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                rd_en,
	input  logic [AW-1:0]       rd_addr,
	output bss_pkg::slot_entry_t rd_entry,
	output logic [TW-1:0]       rd_time,
	input  logic                wr_en,
	input  logic [AW-1:0]       wr_addr,
	input  bss_pkg::slot_entry_t wr_entry,
	input  logic [TW-1:0]       wr_time
);
	import bss_pkg::*;

	slot_entry_t       mem_entry [DEPTH];
	logic [TW-1:0]     mem_time  [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	slot_entry_t       rd_entry_s1;
	logic [TW-1:0]     rd_time_s1;
	logic              rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_entry[wr_addr] <= wr_entry;
			mem_time[wr_addr]  <= wr_time;
		end
		if (rd_en) begin
			rd_entry_s1 <= mem_entry[rd_addr];
			rd_time_s1  <= mem_time[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			if (wr_en) vld_q[wr_addr] <= 1'b1;
			if (rd_en) rd_vld_s1 <= vld_q[rd_addr];
		end
	end

	// never-written entries read as the cleared slot
	assign rd_entry = rd_vld_s1 ? rd_entry_s1 : '0;
	assign rd_time  = rd_vld_s1 ? rd_time_s1 : '0;

endmodule

FILE: hw/rtl/bss_div.sv
// Bit-serial remainder unit: 32-bit dividend modulo a narrow divisor.
module bss_div #(
	parameter int DW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [31:0]   dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] rem
);
	logic [31:0]   dvd_q;
	logic [DW-1:0] dsr_q;
	logic [DW-1:0] rem_q;
	logic [4:0]    cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;

	assign trial = {rem_q, dvd_q[31]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[30:0], 1'b0};
			// one quotient bit a cycle; keep only the partial remainder
			if (trial >= {1'b0, dsr_q}) rem_q <= DW'(trial - {1'b0, dsr_q});
			else rem_q <= DW'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

FILE: hw/rtl/backend_server_selector.sv
// Backend server selector: command sequencer over the slot table.
// Tick and unknown commands go to the response; slot commands read their slot,
// then modify and write it back. Select: per scanned slot a table read, then a
// check and write back, over up to MAX_SERVERS slots; weighted mode adds a
// best-slot write back, hash mode a serial remainder and a walk to its start.
// One command at a time; reset clears the table valid bits, time and registers.
module backend_server_selector #(
	parameter int MAX_SERVERS = bss_pkg::MAX_SERVERS_DEF,
	parameter int TIME_BITS   = bss_pkg::TIME_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  bss_pkg::bss_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output bss_pkg::bss_out_t out_data,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data
);
	import bss_pkg::*;

	localparam int SLOT_W = $clog2(MAX_SERVERS);
	localparam int CNT_W  = $clog2(MAX_SERVERS + 1);
	localparam int TOT_W  = 8 + SLOT_W;
	localparam int SUM_W  = ((TOT_W > 14) ? TOT_W : 14) + 2;
	localparam logic [SLOT_W-1:0] LAST_IDX = SLOT_W'(MAX_SERVERS - 1);

	typedef enum logic [3:0] {
		S_IDLE, S_DIV, S_FIND, S_RD, S_EV, S_BEST, S_CMD_RD, S_CMD_EV, S_RESP
	} state_t;

	function automatic logic signed [13:0] sat_cw(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(CW_MAX)) return 14'sd8191;
		if (v < SUM_W'(CW_MIN)) return -14'sd8192;
		return 14'(v);
	endfunction

	state_t                state_q;
	bss_in_t               in_q;
	bss_out_t              out_q;
	logic                  out_valid_q;
	logic [3:0]            res_slot_q;
	logic                  res_valid_q;
	logic [1:0]            lb_mode_q;
	logic [7:0]            fail_limit_q;
	logic [15:0]           fail_window_q;
	logic [15:0]           conn_limit_q;
	logic [TIME_BITS-1:0]  now_q;
	logic [SLOT_W-1:0]     rr_q;
	logic [MAX_SERVERS-1:0] occ_q;
	logic [CNT_W-1:0]      occ_cnt_q;
	logic [SLOT_W-1:0]     idx_q;
	logic [SLOT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]      seen_q;
	logic [CNT_W-1:0]      target_q;
	logic [SLOT_W-1:0]     best_q;
	logic                  found_q;
	slot_entry_t           best_entry_q;
	logic [TIME_BITS-1:0]  best_time_q;
	logic [15:0]           minc_q;
	logic [TOT_W-1:0]      total_q;

	logic                  accept;
	logic [SLOT_W-1:0]     slot_idx;
	logic                  rd_en;
	logic [SLOT_W-1:0]     rd_addr;
	slot_entry_t           e;
	logic [TIME_BITS-1:0]  t;
	logic                  wr_en;
	logic [SLOT_W-1:0]     wr_addr;
	slot_entry_t           wr_entry;
	logic [TIME_BITS-1:0]  wr_time;
	logic                  div_start;
	logic                  div_done;
	logic [CNT_W-1:0]      div_rem;

	logic [TIME_BITS-1:0]  age;
	logic                  pre_ok;
	logic                  failed;
	logic                  aged;
	logic                  avail;
	logic                  clr;
	logic signed [SUM_W-1:0] cw_sum;
	logic signed [SUM_W-1:0] cw_diff;
	slot_entry_t           scan_entry;
	slot_entry_t           best_wr;
	slot_entry_t           cmd_entry;
	logic [TIME_BITS-1:0]  cmd_time;
	logic [7:0]            fail_inc;
	logic                  take;
	logic                  found_next;
	logic [SLOT_W-1:0]     best_next;
	logic                  last;
	logic [SLOT_W-1:0]     idx_next;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign slot_idx = SLOT_W'(in_q.slot);
	assign last     = (cnt_q == LAST_IDX);
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// availability of the entry just read
	always_comb begin
		age    = now_q - t;
		pre_ok = (e.weight != 8'd0) && (e.status != SLOT_DOWN) &&
			((conn_limit_q == 16'd0) || (e.conns < conn_limit_q));
		failed = (e.fails >= fail_limit_q);
		aged   = (age >= TIME_BITS'(fail_window_q));
		avail  = pre_ok && (!failed || aged);
		clr    = pre_ok && failed && aged;
		cw_sum = SUM_W'(e.cur_weight) + SUM_W'($signed({1'b0, e.weight}));
		scan_entry = e;
		if (clr) scan_entry.fails = 8'd0;
		if (lb_mode_q == MODE_SWRR && avail) scan_entry.cur_weight = sat_cw(cw_sum);
		case (lb_mode_q)
			MODE_SWRR: take = avail && (!found_q || scan_entry.cur_weight > best_entry_q.cur_weight);
			MODE_LC:   take = avail && (!found_q || e.conns < minc_q);
			default:   take = avail;
		endcase
		found_next = found_q || take;
		best_next  = take ? idx_q : best_q;
		cw_diff = SUM_W'(best_entry_q.cur_weight) - SUM_W'($signed({1'b0, total_q}));
		best_wr = best_entry_q;
		best_wr.cur_weight = sat_cw(cw_diff);
	end

	// read-modify-write of one slot for the slot commands
	always_comb begin
		cmd_entry = e;
		cmd_time  = t;
		fail_inc  = (e.fails == 8'hFF) ? 8'hFF : e.fails + 8'd1;
		case (in_q.cmd)
			CMD_LOAD: begin
				cmd_entry = '0;
				cmd_entry.weight = in_q.weight_in;
				cmd_time = '0;
			end
			CMD_CONN: begin
				if (in_q.open_flag) begin
					if (e.conns != 16'hFFFF) cmd_entry.conns = e.conns + 16'd1;
				end else if (e.conns != 16'd0) begin
					cmd_entry.conns = e.conns - 16'd1;
				end
			end
			CMD_OUTCOME: begin
				if (in_q.pass_flag) begin
					cmd_entry.fails = 8'd0;
				end else begin
					cmd_entry.fails = fail_inc;
					cmd_time = now_q;
				end
			end
			CMD_HEALTH: begin
				if (in_q.pass_flag) begin
					if (e.status != SLOT_UP) begin
						cmd_entry.status = SLOT_UP;
						cmd_entry.fails  = 8'd0;
					end
				end else begin
					cmd_entry.fails = fail_inc;
					cmd_time = now_q;
					if (fail_inc >= fail_limit_q) cmd_entry.status = SLOT_DOWN;
				end
			end
			default: begin
				cmd_entry = e;
			end
		endcase
	end

	always_comb begin
		rd_en   = (state_q == S_RD) || (state_q == S_CMD_RD);
		rd_addr = (state_q == S_CMD_RD) ? slot_idx : idx_q;
		wr_en   = (state_q == S_EV) || (state_q == S_CMD_EV) || (state_q == S_BEST);
		case (state_q)
			S_CMD_EV: begin
				wr_addr  = slot_idx;
				wr_entry = cmd_entry;
				wr_time  = cmd_time;
			end
			S_BEST: begin
				wr_addr  = best_q;
				wr_entry = best_wr;
				wr_time  = best_time_q;
			end
			default: begin
				wr_addr  = idx_q;
				wr_entry = scan_entry;
				wr_time  = t;
			end
		endcase
	end

	assign div_start = accept && (in_data.cmd == CMD_SELECT) &&
		(lb_mode_q == MODE_HASH) && (occ_cnt_q != '0);

	bss_table #(
		.DEPTH (MAX_SERVERS),
		.AW    (SLOT_W),
		.TW    (TIME_BITS)
	) u_table (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_entry (e),
		.rd_time  (t),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_entry (wr_entry),
		.wr_time  (wr_time)
	);

	bss_div #(
		.DW (CNT_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (in_data.client_hash),
		.divisor  (occ_cnt_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			out_valid_q   <= 1'b0;
			lb_mode_q     <= MODE_RR;
			fail_limit_q  <= FAIL_LIMIT_RST;
			fail_window_q <= FAIL_WINDOW_RST;
			conn_limit_q  <= CONN_LIMIT_RST;
			now_q         <= '0;
			rr_q          <= '0;
			occ_q         <= '0;
			occ_cnt_q     <= '0;
			found_q       <= 1'b0;
			in_q          <= '0;
			out_q         <= '0;
			res_slot_q    <= '0;
			res_valid_q   <= 1'b0;
			idx_q         <= '0;
			cnt_q         <= '0;
			seen_q        <= '0;
			target_q      <= '0;
			best_q        <= '0;
			best_entry_q  <= '0;
			best_time_q   <= '0;
			minc_q        <= '0;
			total_q       <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_LB_MODE:     lb_mode_q     <= cfg_data[1:0];
					REG_FAIL_LIMIT:  fail_limit_q  <= cfg_data[7:0];
					REG_FAIL_WINDOW: fail_window_q <= cfg_data;
					REG_CONN_LIMIT:  conn_limit_q  <= cfg_data;
					default:         lb_mode_q     <= lb_mode_q;
				endcase
			end
			if (out_valid_q && out_ready && state_q != S_RESP) out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (accept) begin
						in_q        <= in_data;
						res_slot_q  <= '0;
						res_valid_q <= 1'b0;
						found_q     <= 1'b0;
						total_q     <= '0;
						cnt_q       <= '0;
						case (in_data.cmd)
							CMD_SELECT: begin
								if (lb_mode_q == MODE_HASH) begin
									state_q <= (occ_cnt_q == '0) ? S_RESP : S_DIV;
								end else begin
									idx_q   <= (lb_mode_q == MODE_RR) ? rr_q : '0;
									state_q <= S_RD;
								end
							end
							CMD_TICK: begin
								now_q   <= now_q + 1'b1;
								state_q <= S_RESP;
							end
							CMD_LOAD, CMD_CONN, CMD_OUTCOME, CMD_HEALTH: begin
								state_q <= (32'(in_data.slot) < MAX_SERVERS) ? S_CMD_RD : S_RESP;
							end
							default: state_q <= S_RESP;
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						target_q <= div_rem;
						idx_q    <= '0;
						seen_q   <= '0;
						state_q  <= S_FIND;
					end
				end
				S_FIND: begin
					// walk to the target-th occupied slot
					if (occ_q[idx_q] && seen_q == target_q) begin
						state_q <= S_RD;
					end else begin
						seen_q <= seen_q + CNT_W'(occ_q[idx_q]);
						idx_q  <= idx_q + 1'b1;
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					if (lb_mode_q == MODE_SWRR && avail) total_q <= total_q + TOT_W'(e.weight);
					if (take) begin
						best_q       <= idx_q;
						found_q      <= 1'b1;
						best_entry_q <= scan_entry;
						best_time_q  <= t;
						minc_q       <= e.conns;
					end
					if (take && (lb_mode_q == MODE_RR || lb_mode_q == MODE_HASH)) begin
						res_slot_q  <= 4'(idx_q);
						res_valid_q <= 1'b1;
						if (lb_mode_q == MODE_RR) rr_q <= idx_next;
						state_q <= S_RESP;
					end else if (last) begin
						if (found_next && lb_mode_q == MODE_SWRR) begin
							state_q <= S_BEST;
						end else begin
							if (found_next && lb_mode_q == MODE_LC) begin
								res_slot_q  <= 4'(best_next);
								res_valid_q <= 1'b1;
							end
							state_q <= S_RESP;
						end
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						idx_q   <= idx_next;
						state_q <= S_RD;
					end
				end
				S_BEST: begin
					res_slot_q  <= 4'(best_q);
					res_valid_q <= 1'b1;
					state_q     <= S_RESP;
				end
				S_CMD_RD: state_q <= S_CMD_EV;
				S_CMD_EV: begin
					if (in_q.cmd == CMD_LOAD) begin
						occ_q[slot_idx] <= (in_q.weight_in != 8'd0);
						if (occ_q[slot_idx] && in_q.weight_in == 8'd0)
							occ_cnt_q <= occ_cnt_q - 1'b1;
						else if (!occ_q[slot_idx] && in_q.weight_in != 8'd0)
							occ_cnt_q <= occ_cnt_q + 1'b1;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q        <= 1'b1;
						out_q.chosen_slot  <= res_slot_q;
						out_q.chosen_valid <= res_valid_q;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

FILE: hw/rtl/bss_checker.sv
// Port-level checks of the backend server selector, bound to the top level.
module bss_checker #(
	parameter int MAX_SERVERS = bss_pkg::MAX_SERVERS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input bss_pkg::bss_in_t  in_data,
	input logic              out_valid,
	input logic              out_ready,
	input bss_pkg::bss_out_t out_data
);
	import bss_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	a_no_slot_when_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.chosen_valid |-> out_data.chosen_slot == 4'd0)
		else $error("slot reported without a chosen server");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.chosen_valid |-> 32'(out_data.chosen_slot) < MAX_SERVERS)
		else $error("chosen slot beyond the table");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("new command taken while one is in work");

endmodule

bind backend_server_selector bss_checker #(.MAX_SERVERS(MAX_SERVERS)) u_bss_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);

FILE: tb/sv/tb_backend_server_selector.sv
// Self-checking testbench for the backend server selector: directed table, then random commands.
`timescale 1ns / 100ps

module tb_backend_server_selector;
	import bss_pkg::*;

	localparam int NSLOT = 16;

	logic     clk;
	logic     arst_n;
	logic     in_valid;
	logic     in_ready;
	bss_in_t  in_data;
	logic     out_valid;
	logic     out_ready;
	bss_out_t out_data;
	logic        cfg_we;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	backend_server_selector dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow slot table and registers
	logic [7:0]         sh_weight [NSLOT];
	logic signed [13:0] sh_cw     [NSLOT];
	logic [1:0]         sh_status [NSLOT];
	logic [15:0]        sh_conns  [NSLOT];
	logic [7:0]         sh_fails  [NSLOT];
	logic [31:0]        sh_ftime  [NSLOT];
	logic [31:0]        sh_now;
	logic [3:0]         sh_rr;
	logic [1:0]         r_mode;
	logic [7:0]         r_flimit;
	logic [15:0]        r_fwindow;
	logic [15:0]        r_climit;

	bss_out_t picks_due[$];
	int       n_bad, n_seen, n_sel_hit;
	int       sender_idle, recv_stall;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic logic [13:0] sat14(int v);
		if (v > CW_MAX) return 14'(CW_MAX);
		if (v < CW_MIN) return 14'(CW_MIN);
		return 14'(v);
	endfunction

	// availability check; clears the failure count once the window is over
	function automatic bit slot_free(int s);
		if (sh_weight[s] == 0) return 0;
		if (sh_status[s] == SLOT_DOWN) return 0;
		if (r_climit != 0 && sh_conns[s] >= r_climit) return 0;
		if (sh_fails[s] >= r_flimit) begin
			if (32'(sh_now - sh_ftime[s]) < {16'd0, r_fwindow}) return 0;
			sh_fails[s] = 0;
		end
		return 1;
	endfunction

	function automatic void count_fail(int s);
		if (sh_fails[s] != 8'hff) sh_fails[s]++;
		sh_ftime[s] = sh_now;
	endfunction

	function automatic int pick_server(logic [31:0] hash);
		int best, total, s, cnt, seen, start;
		logic [15:0] minc;
		best = -1; total = 0; cnt = 0; seen = 0; start = 0; minc = 0;
		case (r_mode)
		MODE_RR: begin
			for (int i = 0; i < NSLOT; i++) begin
				s = (sh_rr + i) % NSLOT;
				if (sh_weight[s] != 0 && slot_free(s)) begin
					sh_rr = 4'(s + 1);
					return s;
				end
			end
			return -1;
		end
		MODE_SWRR: begin
			for (s = 0; s < NSLOT; s++) begin
				if (!slot_free(s)) continue;
				sh_cw[s] = sat14(int'(sh_cw[s]) + int'(sh_weight[s]));
				total += sh_weight[s];
				if (best < 0 || sh_cw[s] > sh_cw[best]) best = s;
			end
			if (best >= 0) sh_cw[best] = sat14(int'(sh_cw[best]) - total);
			return best;
		end
		MODE_LC: begin
			for (s = 0; s < NSLOT; s++) begin
				if (!slot_free(s)) continue;
				if (best < 0 || sh_conns[s] < minc) begin
					minc = sh_conns[s];
					best = s;
				end
			end
			return best;
		end
		default: begin
			for (s = 0; s < NSLOT; s++) if (sh_weight[s] != 0) cnt++;
			if (cnt == 0) return -1;
			for (s = 0; s < NSLOT; s++) begin
				if (sh_weight[s] == 0) continue;
				if (seen == int'(hash % cnt)) begin
					start = s;
					break;
				end
				seen++;
			end
			for (int i = 0; i < NSLOT; i++) begin
				s = (start + i) % NSLOT;
				if (sh_weight[s] != 0 && slot_free(s)) return s;
			end
			return -1;
		end
		endcase
	endfunction

	function automatic bss_out_t apply_command(bss_in_t c);
		bss_out_t r;
		int s, got;
		r = '0;
		s = c.slot;
		case (c.cmd)
		CMD_SELECT: begin
			got = pick_server(c.client_hash);
			if (got >= 0) begin
				r.chosen_slot = 4'(got);
				r.chosen_valid = 1'b1;
			end
		end
		CMD_LOAD: begin
			sh_weight[s] = c.weight_in;
			sh_cw[s] = '0; sh_status[s] = SLOT_UNKNOWN;
			sh_conns[s] = '0; sh_fails[s] = '0; sh_ftime[s] = '0;
		end
		CMD_CONN: begin
			if (c.open_flag) begin
				if (sh_conns[s] != 16'hffff) sh_conns[s]++;
			end else if (sh_conns[s] != 0) begin
				sh_conns[s]--;
			end
		end
		CMD_OUTCOME: begin
			if (c.pass_flag) sh_fails[s] = '0;
			else count_fail(s);
		end
		CMD_HEALTH: begin
			if (c.pass_flag) begin
				if (sh_status[s] != SLOT_UP) begin
					sh_status[s] = SLOT_UP;
					sh_fails[s] = '0;
				end
			end else begin
				count_fail(s);
				if (sh_fails[s] >= r_flimit) sh_status[s] = SLOT_DOWN;
			end
		end
		CMD_TICK: sh_now = sh_now + 1;
		default: ;
		endcase
		return r;
	endfunction

	// receiver: stall per phase, check each beat against the oldest expectation
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				n_seen++;
				if (picks_due.size() == 0) begin
					n_bad++;
					if (n_bad <= 10) $display("unexpected result %p", out_data);
				end else begin
					if (out_data.chosen_slot !== picks_due[0].chosen_slot ||
					    out_data.chosen_valid !== picks_due[0].chosen_valid) begin
						n_bad++;
						if (n_bad <= 10)
							$display("mismatch: expected %p got %p", picks_due[0], out_data);
					end
					if (picks_due[0].chosen_valid) n_sel_hit++;
					void'(picks_due.pop_front());
				end
			end
			out_ready <= ($urandom_range(99) >= recv_stall);
		end
	end

	// drive one register write; the caller drops the write enable afterwards
	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(posedge clk);
		case (idx)
		REG_LB_MODE:     r_mode = val[1:0];
		REG_FAIL_LIMIT:  r_flimit = val[7:0];
		REG_FAIL_WINDOW: r_fwindow = val;
		default:         r_climit = val;
		endcase
	endtask

	task automatic drain();
		int guard;
		guard = 0;
		in_valid <= 1'b0;
		while (picks_due.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (60) @(posedge clk);
	endtask

	// drive one beat; check a typed-in value where given
	task automatic send(bss_in_t c, bit fixed, bss_out_t want);
		bss_out_t r;
		bit idle;
		idle = ($urandom_range(99) < sender_idle);
		if (idle) in_valid <= 1'b0;
		while (idle) begin
			@(posedge clk);
			idle = ($urandom_range(99) < sender_idle);
		end
		r = apply_command(c);
		if (fixed && r !== want) begin
			n_bad++;
			if (n_bad <= 10) $display("table row: expected %p predicted %p", want, r);
		end
		picks_due.push_back(r);
		in_valid <= 1'b1;
		in_data <= c;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic bss_in_t mk(logic [2:0] c, logic [3:0] s, logic [7:0] w,
	                              logic o, logic p, logic [31:0] h);
		bss_in_t x;
		x.cmd = c; x.slot = s; x.weight_in = w;
		x.open_flag = o; x.pass_flag = p; x.client_hash = h;
		return x;
	endfunction

	function automatic bss_in_t rand_cmd(int nlive);
		bss_in_t x;
		int k;
		x = bss_in_t'($bits(bss_in_t)'({$urandom, $urandom}));
		k = $urandom_range(99);
		if (k < 40) x.cmd = CMD_SELECT;
		else if (k < 48) x.cmd = CMD_LOAD;
		else if (k < 63) x.cmd = CMD_CONN;
		else if (k < 75) x.cmd = CMD_OUTCOME;
		else if (k < 85) x.cmd = CMD_HEALTH;
		else if (k < 97) x.cmd = CMD_TICK;
		else x.cmd = 3'($urandom_range(7, 6));
		// keep weights mostly nonzero so the table stays populated
		if (x.cmd == CMD_LOAD && nlive < 12 && x.weight_in == 0) x.weight_in = 8'd1;
		return x;
	endfunction

	typedef struct {
		bss_in_t  c;
		bit       fixed;
		bss_out_t want;
	} row_t;

	row_t rows[$];
	bss_out_t none_o, pick;

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0; in_data = '0; out_ready = 1'b0;
		cfg_we = 1'b0; cfg_index = REG_LB_MODE; cfg_data = '0;
		n_bad = 0; n_seen = 0; n_sel_hit = 0;
		sender_idle = 0; recv_stall = 0;
		for (int i = 0; i < NSLOT; i++) begin
			sh_weight[i] = 0; sh_cw[i] = 0; sh_status[i] = 0;
			sh_conns[i] = 0; sh_fails[i] = 0; sh_ftime[i] = 0;
		end
		sh_now = 0; sh_rr = 0;
		r_mode = MODE_RR; r_flimit = FAIL_LIMIT_RST;
		r_fwindow = FAIL_WINDOW_RST; r_climit = CONN_LIMIT_RST;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		none_o = '0;
		pick = '0; pick.chosen_valid = 1'b1;
		rows.push_back('{mk(CMD_SELECT, 4'd0, 8'd0, 0, 0, 32'h0), 1, none_o});
		rows.push_back('{mk(CMD_LOAD, 4'd0, 8'd255, 1, 1, 32'hffffffff), 1, none_o});
		rows.push_back('{mk(CMD_LOAD, 4'd15, 8'd1, 0, 0, 32'h0), 1, none_o});
		pick.chosen_slot = 4'd0;
		rows.push_back('{mk(CMD_SELECT, 4'd0, 8'd0, 0, 0, 32'h0), 1, pick});
		pick.chosen_slot = 4'd15;
		rows.push_back('{mk(CMD_SELECT, 4'd0, 8'd0, 0, 0, 32'h0), 1, pick});
		rows.push_back('{mk(CMD_CONN, 4'd15, 8'd0, 1, 0, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_CONN, 4'd15, 8'd0, 0, 0, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_CONN, 4'd15, 8'd0, 0, 0, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_OUTCOME, 4'd0, 8'd0, 0, 0, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_OUTCOME, 4'd0, 8'd0, 0, 1, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_HEALTH, 4'd0, 8'd0, 0, 1, 32'h0), 0, none_o});
		for (int i = 0; i < 3; i++)
			rows.push_back('{mk(CMD_HEALTH, 4'd15, 8'd0, 0, 0, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_SELECT, 4'd0, 8'd0, 0, 0, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_SELECT, 4'd0, 8'd0, 0, 0, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_HEALTH, 4'd7, 8'd0, 0, 0, 32'h0), 0, none_o});
		rows.push_back('{mk(CMD_TICK, 4'd0, 8'd0, 0, 0, 32'h0), 1, none_o});
		rows.push_back('{mk(3'd6, 4'd3, 8'd9, 1, 1, 32'h5), 1, none_o});
		rows.push_back('{mk(3'd7, 4'd3, 8'd9, 1, 1, 32'h5), 1, none_o});
		rows.push_back('{mk(CMD_LOAD, 4'd0, 8'd0, 0, 0, 32'h0), 1, none_o});
		rows.push_back('{mk(CMD_SELECT, 4'd0, 8'd0, 0, 0, 32'hffffffff), 0, none_o});
		foreach (rows[i]) send(rows[i].c, rows[i].fixed, rows[i].want);
		drain();

		// random phases: each with its own register setting and idling mix
		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
			0: begin sender_idle = 0;  recv_stall = 0;  end
			1: begin sender_idle = 64; recv_stall = 0;  end
			2: begin sender_idle = 0;  recv_stall = 64; end
			default: begin sender_idle = 20; recv_stall = 20; end
			endcase
			write_reg(REG_LB_MODE, 16'(ph % 4));
			write_reg(REG_FAIL_LIMIT, ph == 2 ? 16'd255 : ph == 5 ? 16'd1 :
			          16'($urandom_range(4, 1)));
			write_reg(REG_FAIL_WINDOW, ph == 3 ? 16'hffff : ph == 6 ? 16'd0 :
			          16'($urandom_range(8)));
			write_reg(REG_CONN_LIMIT, ph == 4 ? 16'hffff : ph == 1 ? 16'd0 :
			          16'($urandom_range(4, 1)));
			cfg_we <= 1'b0;
			for (int n = 0; n < 50; n++) begin
				int live;
				live = 0;
				foreach (sh_weight[i]) if (sh_weight[i] != 0) live++;
				send(rand_cmd(live), 0, none_o);
			end
			drain();
		end

		$display("ran %0d commands over four modes and eight register settings,", n_seen);
		$display("%0d selects returned a server", n_sel_hit);
		if (n_bad == 0 && picks_due.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d left waiting", n_bad, picks_due.size());
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
